FILE: rtl/info0_frame_decode_assert.svh
// Assertion helpers for the decode RTL.
`ifndef INFO0_FRAME_DECODE_ASSERT_SVH
`define INFO0_FRAME_DECODE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define I0FD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("i0fd check failed: same-cycle rule");

// Next-cycle implication, checked while out of reset.
`define I0FD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("i0fd check failed: next-cycle rule");

`endif

FILE: rtl/i0fd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i0fd_pkg;

  localparam int unsigned FrameW   = 49;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  localparam logic [3:0]  FillCode    = 4'hF;
  localparam logic [7:0]  SyncCode    = 8'h4E;
  localparam logic [15:0] CrcPoly     = 16'h8408;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [2:0]  MaxRateDiff = 3'd5;
  localparam logic [1:0]  MaxClock    = 2'd2;

  // Declared MSB first, so frame_ok lands in bit 0 of the packed value.
  typedef struct packed {
    logic       ack_flag;
    logic [1:0] clock_mode;
    logic       big_constellation;
    logic       cme_flag;
    logic [2:0] rate_difference;
    logic       power_reduce;
    logic       allow_high_rate;
    logic [3:0] carrier_flags;
    logic [2:0] rate_flags;
    logic       frame_ok;
  } info_res_t;

  localparam int unsigned ResW = $bits(info_res_t);

  // Reflected CRC-16 over the 17 capability bits, first sent bit first.
  // Fixed length and linear, so this folds into a flat XOR network.
  function automatic logic [15:0] info_crc(input logic [16:0] bits);
    logic [15:0] crc;
    logic        fb;
    crc = CrcInit;
    for (int i = 0; i < 17; i++) begin
      fb  = crc[0] ^ bits[i];
      crc = {1'b0, crc[15:1]};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/i0fd_check.sv
`timescale 1ns / 1ps
`default_nettype none
module i0fd_check
  import i0fd_pkg::*;
(
  input  logic [FrameW-1:0] frame_i,
  output info_res_t         res_o
);

  logic      framed;
  logic      in_range;
  info_res_t fields;

  always_comb begin
    framed = (frame_i[3:0] == FillCode) &&
             (frame_i[11:4] == SyncCode) &&
             (frame_i[48:45] == FillCode) &&
             (frame_i[44:29] == info_crc(frame_i[28:12]));

    fields.rate_flags        = frame_i[14:12];
    fields.carrier_flags     = frame_i[18:15];
    fields.allow_high_rate   = frame_i[19];
    fields.power_reduce      = frame_i[20];
    fields.rate_difference   = frame_i[23:21];
    fields.cme_flag          = frame_i[24];
    fields.big_constellation = frame_i[25];
    fields.clock_mode        = frame_i[27:26];
    fields.ack_flag          = frame_i[28];

    in_range = (fields.rate_difference <= MaxRateDiff) &&
               (fields.clock_mode <= MaxClock);
    fields.frame_ok = in_range;

    // a framing or CRC miss blanks the whole result
    res_o = framed ? fields : '0;
  end

endmodule
`default_nettype wire

FILE: rtl/info0_frame_decode.sv
// Stages: input register, then result register.
// Throughput: one frame per cycle without output stalls; check and unpack are one pass.
// The input stage takes a new frame whenever it is empty or moves on this cycle.
// Reset (rst_ni low, asynchronous) empties both stages; payload is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "info0_frame_decode_assert.svh"
module info0_frame_decode
  import i0fd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // [48:0] frame_bits, rest zero
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] frame_ok, [3:1] rate_flags, [7:4] carrier_flags, [8] allow_high_rate,
  // [9] power_reduce, [12:10] rate_difference, [13] cme_flag,
  // [14] big_constellation, [16:15] clock_mode, [17] ack_flag, rest zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic              in_vld_q, in_vld_d;
  logic [FrameW-1:0] frame_q;
  logic              out_vld_q, out_vld_d;
  info_res_t         res_q;
  info_res_t         res_d;
  logic              out_adv;
  logic              in_fire;

  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || out_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_vld_d  = in_fire ? 1'b1 : (out_adv ? 1'b0 : in_vld_q);
  assign out_vld_d = out_adv ? in_vld_q : out_vld_q;

  i0fd_check u_check (
    .frame_i (frame_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q <= s_axis_tdata_i[FrameW-1:0];
    end
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - ResW){1'b0}}, res_q};

  `I0FD_ASSERT_NEXT(a_in_loaded, clk_i, rst_ni, in_fire, in_vld_q)
  `I0FD_ASSERT_NEXT(a_in_held, clk_i, rst_ni, in_vld_q && !out_adv,
    in_vld_q && $stable(frame_q))
  `I0FD_ASSERT_NOW(a_ok_in_range, clk_i, rst_ni, out_vld_q && res_q.frame_ok,
    (res_q.rate_difference <= MaxRateDiff) && (res_q.clock_mode != 2'd3))
  `I0FD_ASSERT_NOW(a_bad_is_blank_or_range, clk_i, rst_ni,
    out_vld_q && !res_q.frame_ok && (res_q != '0),
    (res_q.rate_difference > MaxRateDiff) || (res_q.clock_mode > MaxClock))

endmodule
`default_nettype wire

FILE: tb/info0_frame_decode_tb.sv
`timescale 1ns / 1ps
module info0_frame_decode_tb;
  import i0fd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainCycles = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;   // [48:0] frame_bits, rest zero
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [0] frame_ok, [3:1] rate_flags, [7:4] carrier_flags, [8] allow_high_rate,
  // [9] power_reduce, [12:10] rate_difference, [13] cme_flag,
  // [14] big_constellation, [16:15] clock_mode, [17] ack_flag, rest zero
  logic [OutDataW-1:0] m_axis_tdata_o;

  info_res_t   decoded_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned frames_sent;
  int unsigned n_ok;
  int unsigned n_range;
  int unsigned n_reject;
  int unsigned cycles;
  bit          quiet;

  info0_frame_decode dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, decoded_q.size());
      $display("info0_frame_decode regression: fail");
      $finish;
    end
  end

  // Reflected CRC-16 over the 17 capability bits, lowest (first sent) bit first.
  function automatic logic [15:0] caps_crc(input logic [16:0] caps);
    logic [15:0] r;
    r = CrcInit;
    for (int k = 0; k < 17; k++) begin
      r = (r >> 1) ^ ({16{r[0] ^ caps[k]}} & CrcPoly);
    end
    return r;
  endfunction

  function automatic logic [48:0] build_frame(input logic [16:0] caps);
    return {FillCode, caps_crc(caps), caps, SyncCode, FillCode};
  endfunction

  function automatic logic [16:0] make_caps(input logic [2:0] rates, input logic [3:0] carriers,
                                            input logic ahr, input logic pwr,
                                            input logic [2:0] rdiff, input logic cme,
                                            input logic big, input logic [1:0] clk_src,
                                            input logic ack);
    return {ack, clk_src, big, cme, rdiff, pwr, ahr, carriers, rates};
  endfunction

  function automatic info_res_t predict_decode(input logic [48:0] f);
    info_res_t r;
    logic      framed;
    r = '0;
    framed = (f[3:0] == FillCode) && (f[11:4] == SyncCode) && (f[48:45] == FillCode) &&
             (f[44:29] == caps_crc(f[28:12]));
    if (framed) begin
      r.rate_flags        = f[14:12];
      r.carrier_flags     = f[18:15];
      r.allow_high_rate   = f[19];
      r.power_reduce      = f[20];
      r.rate_difference   = f[23:21];
      r.cme_flag          = f[24];
      r.big_constellation = f[25];
      r.clock_mode        = f[27:26];
      r.ack_flag          = f[28];
      r.frame_ok = (r.rate_difference <= MaxRateDiff) && (r.clock_mode <= MaxClock);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    info_res_t got;
    info_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      got = info_res_t'(m_axis_tdata_o[ResW-1:0]);
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result %0d arrived with no frame pending: 0x%0h", results_seen,
                   m_axis_tdata_o);
        end
      end else begin
        want = decoded_q.pop_front();
        compare_field("frame_ok", want.frame_ok, got.frame_ok);
        compare_field("rate_flags", want.rate_flags, got.rate_flags);
        compare_field("carrier_flags", want.carrier_flags, got.carrier_flags);
        compare_field("allow_high_rate", want.allow_high_rate, got.allow_high_rate);
        compare_field("power_reduce", want.power_reduce, got.power_reduce);
        compare_field("rate_difference", want.rate_difference, got.rate_difference);
        compare_field("cme_flag", want.cme_flag, got.cme_flag);
        compare_field("big_constellation", want.big_constellation, got.big_constellation);
        compare_field("clock_mode", want.clock_mode, got.clock_mode);
        compare_field("ack_flag", want.ack_flag, got.ack_flag);
        compare_field("padding", 0, m_axis_tdata_o[OutDataW-1:ResW]);
      end
    end
  end

  // Receiver stalls about one cycle in ten unless a burst is running.
  always @(negedge clk_i) begin
    m_axis_tready_i = quiet || ($urandom_range(99) >= 10);
  end

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with tvalid still high so back-to-back items need no gap.
  task automatic send_frame(input logic [48:0] f);
    info_res_t r;
    if (!quiet && $urandom_range(99) < 10) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = InDataW'(f);
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = predict_decode(f);
    decoded_q.push_back(r);
    frames_sent++;
    if (r.frame_ok) n_ok++;
    else if (r != '0) n_range++;
    else n_reject++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_good_frames();
    send_frame(build_frame('0));
    send_frame(build_frame(make_caps(3'd7, 4'hF, 1'b1, 1'b1, MaxRateDiff, 1'b1, 1'b1,
                                     MaxClock, 1'b1)));
    send_frame(build_frame(make_caps(3'd1, 4'h5, 1'b0, 1'b1, 3'd6, 1'b0, 1'b1, 2'd0, 1'b0)));
    send_frame(build_frame(make_caps(3'd2, 4'hA, 1'b1, 1'b0, 3'd7, 1'b1, 1'b0, 2'd1, 1'b1)));
    send_frame(build_frame(make_caps(3'd4, 4'h3, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 2'd3, 1'b0)));
    send_frame(build_frame(make_caps(3'd0, 4'h0, 1'b0, 1'b0, MaxRateDiff, 1'b0, 1'b0,
                                     MaxClock, 1'b0)));
    send_frame(build_frame(17'h1FFFF));
  endtask

  task automatic test_framing_errors();
    logic [48:0] good;
    good = build_frame(make_caps(3'd5, 4'hA, 1'b1, 1'b0, 3'd3, 1'b1, 1'b0, 2'd1, 1'b0));
    send_frame(good);
    send_frame(good ^ (49'd1 << 0));    // opening fill
    send_frame(good ^ (49'd1 << 7));    // sync
    send_frame(good ^ (49'd1 << 48));   // closing fill
    send_frame(good ^ (49'd1 << 29));   // CRC low bit
    send_frame(good ^ (49'd1 << 44));   // CRC high bit
    send_frame(good ^ (49'd1 << 20));   // payload changed, CRC stale
    send_frame('0);
    send_frame('1);
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 4; k++) begin
      send_frame(build_frame(17'($urandom())));
    end
    wait_drained();
    repeat ($urandom_range(2, 6)) @(negedge clk_i);
  endtask

  // Mostly well-formed frames with random capabilities, some with one bit hit,
  // and some raw noise.
  task automatic test_random_frames(input int unsigned count);
    logic [63:0] noise;
    logic [48:0] f;
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      noise = {$urandom(), $urandom()};
      f = build_frame(17'($urandom()));
      if (pick >= 85) f = noise[48:0];
      else if (pick >= 70) f = f ^ (49'd1 << $urandom_range(48));
      send_frame(f);
    end
  endtask

  task automatic test_burst_frames(input int unsigned count);
    quiet = 1'b1;
    test_random_frames(count);
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    quiet           = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_good_frames();
    test_framing_errors();
    test_drain_pause();
    test_random_frames(350);
    test_burst_frames(150);
    test_random_frames(300);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    $display("sent %0d frames: %0d clean, %0d out of range, %0d dropped on fill/sync/CRC",
             frames_sent, n_ok, n_range, n_reject);
    $display("checked %0d results, %0d field mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("info0_frame_decode regression: pass");
    end else begin
      $display("info0_frame_decode regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/i0fd_pkg.sv
rtl/i0fd_check.sv
rtl/info0_frame_decode.sv
tb/info0_frame_decode_tb.sv
